@@ rtl/bmp_pkg.sv @@
package bmp_pkg;

  localparam int unsigned DimBitsDef = 12;
  localparam int unsigned CfgAddrBits = 3;
  localparam logic [7:0] PadByte = 8'h41;

  localparam logic [15:0] RedMask = 16'hF800;
  localparam logic [15:0] GreenMask = 16'h07E0;
  localparam logic [15:0] BlueMask = 16'h001F;

  localparam logic ReqData = 1'b0;
  localparam logic ReqFinish = 1'b1;

  localparam logic [CfgAddrBits-1:0] AddrWidth = 3'd0;
  localparam logic [CfgAddrBits-1:0] AddrHeight = 3'd4;

  // Index of the last beat of a result group.
  localparam logic [1:0] BeatFinish = 2'd0;
  localparam logic [1:0] BeatPixel = 2'd1;
  localparam logic [1:0] BeatPadded = 2'd3;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_COMPLETE   = 2'd1,
    STAT_INCOMPLETE = 2'd2
  } status_e;

  // One group of results caused by one input item.
  typedef struct packed {
    logic [15:0] pixel;
    logic [1:0]  last_beat;
    logic        image_end;
    logic        finish;
    logic        finish_ok;
  } desc_t;

  function automatic logic [15:0] pack_rgb565(input logic [7:0] blue,
                                              input logic [7:0] green,
                                              input logic [7:0] red);
    logic [15:0] px;
    px = (({8'd0, red} >> 3) << 11) & RedMask;
    px = px | ((({8'd0, green} >> 2) << 5) & GreenMask);
    px = px | (({8'd0, blue} >> 3) & BlueMask);
    return px;
  endfunction

endpackage

@@ rtl/bmp_rgb888_to_rgb565_stream_top.sv @@
// Converts the pixel array of a bottom-up 24-bit bitmap into an RGB565 byte stream.
// Input channel: one item per byte (req_type_i = 0, data_byte_i blue first) or a
// finish item (req_type_i = 1) that returns one status result. An item is taken at
// a clock edge with in_valid_i high and in_stall_o low.
// Output channel: each completed pixel gives two bytes, low byte first, followed at
// the end of a row by two 0x41 padding bytes when the width is odd. Input row padding
// and bytes after the last row give no result. last_of_run_o marks the last result of
// an item and image_done_o the final byte of the image, or a finish on a complete one.
// With the result queue empty, the first result of an item is valid in the cycle after it is
// accepted; the results of one item then leave one per unstalled cycle, and a pixel takes
// three input bytes and gives two to four output bytes. A two-entry result queue sets the
// throughput: the input stalls only while both entries hold result groups.
// Reset clears the pixel, row and column position, empties the queue and sets both
// size registers to 1. While out_stall_i is high the current result holds steady and
// input keeps flowing until the queue fills. Width and height are written through the
// APB port at 0x0 and 0x4, by the user only while idle; the block does not enforce this.
module bmp_rgb888_to_rgb565_stream_top import bmp_pkg::*; #(
  parameter int unsigned DIM_BITS = DimBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CfgAddrBits-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   req_type_i,
  input  logic [7:0]             data_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             out_byte_o,
  output logic                   is_padding_o,
  output logic                   last_of_run_o,
  output logic                   image_done_o,
  output logic [1:0]             status_o
);

  logic [DIM_BITS-1:0] width_q, height_q;
  logic                cfg_wr;
  logic                accept;
  logic                push;
  desc_t               desc;
  logic                full;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= {{(DIM_BITS-1){1'b0}}, 1'b1};
      height_q <= {{(DIM_BITS-1){1'b0}}, 1'b1};
    end else if (cfg_wr) begin
      if (paddr == AddrWidth) begin
        width_q <= pwdata[DIM_BITS-1:0];
      end
      if (paddr == AddrHeight) begin
        height_q <= pwdata[DIM_BITS-1:0];
      end
    end
  end

  always_comb begin
    unique case (paddr)
      AddrWidth:  prdata = {{(32-DIM_BITS){1'b0}}, width_q};
      AddrHeight: prdata = {{(32-DIM_BITS){1'b0}}, height_q};
      default:    prdata = 32'd0;
    endcase
  end

  assign in_stall_o = full;
  assign accept = in_valid_i && !full;

  bmp_core #(
    .DIM_BITS(DIM_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .req_type_i  (req_type_i),
    .data_byte_i (data_byte_i),
    .width_i     (width_q),
    .height_i    (height_q),
    .push_o      (push),
    .desc_o      (desc)
  );

  bmp_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .desc_i        (desc),
    .full_o        (full),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .is_padding_o  (is_padding_o),
    .last_of_run_o (last_of_run_o),
    .image_done_o  (image_done_o),
    .status_o      (status_o)
  );

  // The input only stalls when a result group is already on the output.
  a_stall_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result on the output");

  // A finish result is always a run of one.
  a_finish_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STAT_OK) |-> (last_of_run_o && !is_padding_o))
    else $error("finish result is not a single result");

  // The end of the image only comes on the last byte of a pixel group.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && image_done_o && status_o == STAT_OK) |-> last_of_run_o)
    else $error("image end flagged before the last result of its group");

  // A finished group with a stalled receiver keeps its last result until taken.
  a_hold_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i && last_of_run_o) |=> (out_valid_o && last_of_run_o))
    else $error("last result dropped while the output was stalled");

endmodule

@@ rtl/bmp_core.sv @@
module bmp_core import bmp_pkg::*; #(
  parameter int unsigned DIM_BITS = DimBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                req_type_i,
  input  logic [7:0]          data_byte_i,
  input  logic [DIM_BITS-1:0] width_i,
  input  logic [DIM_BITS-1:0] height_i,
  output logic                push_o,
  output desc_t               desc_o
);

  logic [DIM_BITS-1:0] column_q, column_d;
  logic [DIM_BITS-1:0] row_q, row_d;
  logic [1:0]          phase_q, phase_d;
  logic [15:0]         held_q, held_d;
  logic [1:0]          skip_q, skip_d;
  logic                done_q, done_d;

  logic                complete;
  logic [DIM_BITS-1:0] col_next;
  logic [DIM_BITS-1:0] row_next;
  logic                row_end;
  logic                last_row;
  logic [1:0]          w4;

  assign complete = done_q || (width_i == '0) || (height_i == '0) || (row_q >= height_i);
  assign col_next = column_q + {{(DIM_BITS-1){1'b0}}, 1'b1};
  assign row_next = row_q + {{(DIM_BITS-1){1'b0}}, 1'b1};
  assign row_end = col_next >= width_i;
  assign last_row = ({1'b0, row_q} + {{DIM_BITS{1'b0}}, 1'b1}) >= {1'b0, height_i};
  // Input row padding equals width mod 4; output padding is two bytes for odd widths.
  assign w4 = width_i[1:0];

  always_comb begin
    column_d = column_q;
    row_d = row_q;
    phase_d = phase_q;
    held_d = held_q;
    skip_d = skip_q;
    done_d = done_q;
    push_o = 1'b0;
    desc_o.pixel = pack_rgb565(held_q[7:0], held_q[15:8], data_byte_i);
    desc_o.last_beat = BeatPixel;
    desc_o.image_end = 1'b0;
    desc_o.finish = 1'b0;
    desc_o.finish_ok = complete;

    if (accept_i) begin
      if (req_type_i == ReqFinish) begin
        push_o = 1'b1;
        desc_o.finish = 1'b1;
        desc_o.last_beat = BeatFinish;
      end else if (!complete) begin
        if (skip_q != 2'd0) begin
          skip_d = skip_q - 2'd1;
          if (skip_q == 2'd1) begin
            column_d = '0;
            row_d = row_next;
            if (row_next >= height_i) begin
              done_d = 1'b1;
            end
          end
        end else if (phase_q == 2'd0) begin
          held_d = {8'd0, data_byte_i};
          phase_d = 2'd1;
        end else if (phase_q == 2'd1) begin
          held_d = {data_byte_i, held_q[7:0]};
          phase_d = 2'd2;
        end else begin
          push_o = 1'b1;
          phase_d = 2'd0;
          held_d = '0;
          column_d = col_next;
          if (row_end) begin
            desc_o.last_beat = w4[0] ? BeatPadded : BeatPixel;
            desc_o.image_end = last_row;
            if (w4 != 2'd0) begin
              skip_d = w4;
            end else begin
              column_d = '0;
              row_d = row_next;
              if (row_next >= height_i) begin
                done_d = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      row_q <= '0;
      phase_q <= 2'd0;
      held_q <= '0;
      skip_q <= 2'd0;
      done_q <= 1'b0;
    end else begin
      column_q <= column_d;
      row_q <= row_d;
      phase_q <= phase_d;
      held_q <= held_d;
      skip_q <= skip_d;
      done_q <= done_d;
    end
  end

endmodule

@@ rtl/bmp_emit.sv @@
module bmp_emit import bmp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  desc_t      desc_i,
  output logic       full_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       is_padding_o,
  output logic       last_of_run_o,
  output logic       image_done_o,
  output logic [1:0] status_o
);

  desc_t      act_q, act_d;
  desc_t      pend_q, pend_d;
  logic       act_v_q, act_v_d;
  logic       pend_v_q, pend_v_d;
  logic [1:0] beat_q, beat_d;
  logic       last_beat;
  logic       act_free;

  assign last_beat = beat_q == act_q.last_beat;
  assign act_free = !act_v_q || (!out_stall_i && last_beat);
  assign full_o = pend_v_q;

  always_comb begin
    act_d = act_q;
    pend_d = pend_q;
    act_v_d = act_v_q;
    pend_v_d = pend_v_q;
    beat_d = beat_q;
    if (act_free) begin
      beat_d = 2'd0;
      if (pend_v_q) begin
        act_d = pend_q;
        act_v_d = 1'b1;
        pend_d = desc_i;
        pend_v_d = push_i;
      end else begin
        act_d = desc_i;
        act_v_d = push_i;
      end
    end else begin
      if (!out_stall_i) begin
        beat_d = beat_q + 2'd1;
      end
      if (push_i) begin
        pend_d = desc_i;
        pend_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_v_q <= 1'b0;
      pend_v_q <= 1'b0;
      beat_q <= 2'd0;
    end else begin
      act_v_q <= act_v_d;
      pend_v_q <= pend_v_d;
      beat_q <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    pend_q <= pend_d;
  end

  always_comb begin
    out_valid_o = act_v_q;
    last_of_run_o = last_beat;
    if (act_q.finish) begin
      out_byte_o = 8'd0;
      is_padding_o = 1'b0;
      image_done_o = act_q.finish_ok;
      status_o = act_q.finish_ok ? STAT_COMPLETE : STAT_INCOMPLETE;
    end else begin
      is_padding_o = beat_q[1];
      image_done_o = last_beat && act_q.image_end;
      status_o = STAT_OK;
      case (beat_q)
        2'd0:    out_byte_o = act_q.pixel[7:0];
        2'd1:    out_byte_o = act_q.pixel[15:8];
        default: out_byte_o = PadByte;
      endcase
    end
  end

endmodule

@@ tb/bmp_rgb888_to_rgb565_stream_top_tb.sv @@
`timescale 1ns / 1ps

module bmp_rgb888_to_rgb565_stream_top_tb;
  import bmp_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseItems = 20;
  localparam int unsigned LongHold = 80;

  typedef struct packed {
    logic       req;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic       is_pad;
    logic       run_end;
    logic       img_end;
    status_e    status;
  } px_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [CfgAddrBits-1:0] paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic                   req_type_i = ReqData;
  logic [7:0]             data_byte_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [7:0]             out_byte_o;
  logic                   is_padding_o;
  logic                   last_of_run_o;
  logic                   image_done_o;
  logic [1:0]             status_o;

  bmp_rgb888_to_rgb565_stream_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .is_padding_o (is_padding_o),
    .last_of_run_o(last_of_run_o),
    .image_done_o (image_done_o),
    .status_o     (status_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  in_item_t   pending_bytes[$];
  px_result_t expected_out[$];

  // Converter state as the testbench sees it.
  logic [11:0] img_width = 12'd1;
  logic [11:0] img_height = 12'd1;
  logic [11:0] col_idx = '0;
  logic [11:0] row_idx = '0;
  logic [1:0]  px_phase = '0;
  logic [15:0] held = '0;
  logic [1:0]  skip_left = '0;
  logic        img_finished = 1'b0;

  logic        item_taken = 1'b0;
  int unsigned src_gap = 0;
  int unsigned snk_gap = 0;
  int unsigned src_pct = 0;
  int unsigned snk_pct = 0;
  int unsigned hold_left = 0;
  logic        hold_req = 1'b0;
  logic        calm = 1'b0;

  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned n_data = 0;
  int unsigned n_finish = 0;
  int unsigned n_checked = 0;
  int unsigned n_pad = 0;

  function automatic logic image_closed();
    return img_finished || img_width == '0 || img_height == '0 || row_idx >= img_height;
  endfunction

  task automatic close_row();
    col_idx = '0;
    row_idx = row_idx + 12'd1;
    if (row_idx >= img_height) img_finished = 1'b1;
  endtask

  task automatic convert_item(input logic req, input logic [7:0] b);
    px_result_t grp[4];
    logic [15:0] px;
    logic        row_end;
    logic        last_row;
    int          n;
    n = 0;
    if (req == ReqFinish) begin
      grp[0] = '{8'h00, 1'b0, 1'b1, image_closed(),
                 image_closed() ? STAT_COMPLETE : STAT_INCOMPLETE};
      n = 1;
    end else if (image_closed()) begin
      n = 0;
    end else if (skip_left != '0) begin
      skip_left = skip_left - 2'd1;
      if (skip_left == '0) close_row();
    end else if (px_phase == 2'd0) begin
      held = {8'h00, b};
      px_phase = 2'd1;
    end else if (px_phase == 2'd1) begin
      held[15:8] = b;
      px_phase = 2'd2;
    end else begin
      // Red is the byte in hand, green and blue were held.
      px = {b[7:3], held[15:10], held[7:3]};
      px_phase = 2'd0;
      held = '0;
      col_idx = col_idx + 12'd1;
      row_end = col_idx >= img_width;
      last_row = ({1'b0, row_idx} + 13'd1) >= {1'b0, img_height};
      grp[0] = '{px[7:0], 1'b0, 1'b0, 1'b0, STAT_OK};
      grp[1] = '{px[15:8], 1'b0, 1'b0, 1'b0, STAT_OK};
      n = 2;
      if (row_end) begin
        // An odd width leaves the output row two bytes short of a word.
        if (img_width[0]) begin
          grp[2] = '{PadByte, 1'b1, 1'b0, 1'b0, STAT_OK};
          grp[3] = '{PadByte, 1'b1, 1'b0, 1'b0, STAT_OK};
          n = 4;
        end
        grp[n-1].img_end = last_row;
        // A 3*width byte input row needs width mod 4 bytes to reach a word.
        if (img_width[1:0] != 2'd0) skip_left = img_width[1:0];
        else close_row();
      end
      grp[n-1].run_end = 1'b1;
    end
    for (int k = 0; k < n; k++) expected_out.push_back(grp[k]);
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still expected", cycles,
               expected_out.size());
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin : mon
    px_result_t got;
    px_result_t want;
    item_taken = in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.value = out_byte_o;
      got.is_pad = is_padding_o;
      got.run_end = last_of_run_o;
      got.img_end = image_done_o;
      got.status = status_e'(status_o);
      n_checked++;
      if (is_padding_o) n_pad++;
      if (expected_out.size() == 0) begin
        errors++;
        $display("%0t: expected no result, actual byte %02h pad %0b last %0b done %0b status %0d",
                 $time, got.value, got.is_pad, got.run_end, got.img_end, got.status);
      end else begin
        want = expected_out.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: expected byte %02h pad %0b last %0b done %0b status %0d", $time,
                   want.value, want.is_pad, want.run_end, want.img_end, want.status);
          $display("%0t:   actual byte %02h pad %0b last %0b done %0b status %0d", $time,
                   got.value, got.is_pad, got.run_end, got.img_end, got.status);
        end
      end
    end
    if (rst_ni && item_taken) begin
      if (req_type_i == ReqFinish) n_finish++;
      else n_data++;
      convert_item(req_type_i, data_byte_i);
    end
  end

  always @(negedge clk_i) begin : drv
    in_item_t nxt;
    logic     offer;
    if (rst_ni && (!in_valid_i || item_taken)) begin
      offer = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
      end else if (!calm && pending_bytes.size() > 0 && $urandom_range(0, 99) < src_pct) begin
        src_gap = $urandom_range(0, 10);
      end else if (pending_bytes.size() > 0) begin
        nxt = pending_bytes.pop_front();
        offer = 1'b1;
        req_type_i <= nxt.req;
        data_byte_i <= nxt.data;
      end
      in_valid_i <= offer;
    end
  end

  always @(negedge clk_i) begin : sink
    logic hold;
    if (rst_ni) begin
      if (hold_req && hold_left == 0) begin
        hold_left = LongHold;
        hold_req = 1'b0;
      end
      hold = 1'b1;
      if (hold_left > 0) hold_left--;
      else if (snk_gap > 0) snk_gap--;
      else if (!calm && $urandom_range(0, 99) < snk_pct) snk_gap = $urandom_range(0, 10);
      else hold = 1'b0;
      out_stall_i <= hold;
    end
  end

  task automatic reg_write(input logic [CfgAddrBits-1:0] addr, input logic [11:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {20'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == AddrWidth) img_width = value;
    else img_height = value;
    @(posedge clk_i);
  endtask

  // Items that cause no result may still be inside the block, hence the tail.
  task automatic drain();
    do @(posedge clk_i);
    while (pending_bytes.size() != 0 || in_valid_i || expected_out.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic push_data(input logic [7:0] b);
    pending_bytes.push_back('{ReqData, b});
  endtask

  task automatic push_finish(input logic [7:0] b);
    pending_bytes.push_back('{ReqFinish, b});
  endtask

  task automatic push_random(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(0, 11) == 0) push_finish(8'($urandom_range(0, 255)));
      else push_data(8'($urandom_range(0, 255)));
    end
  endtask

  int unsigned row_widths[8] = '{5, 4095, 1, 3, 2, 7, 4, 6};

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A 1x1 image: finish before and after its only pixel, whose row padding is still owed.
    push_finish(8'h00);
    push_data(8'h00);
    push_data(8'h00);
    push_data(8'h00);
    push_finish(8'hFF);
    drain();
    reg_write(AddrHeight, 12'd4095);
    // The first byte is the owed row padding, the last one pads the new row.
    push_data(8'hFF);
    push_data(8'hFF);
    push_data(8'hFF);
    push_data(8'hFF);
    push_data(8'hAB);
    push_finish(8'hFF);
    drain();
    reg_write(AddrWidth, 12'd0);
    push_data(8'h5A);
    push_finish(8'h00);
    drain();
    reg_write(AddrWidth, 12'd2);
    reg_write(AddrHeight, 12'd0);
    push_data(8'hA5);
    push_finish(8'h00);
    drain();
    reg_write(AddrHeight, 12'd4095);
    push_data(8'h07);
    push_data(8'hFC);
    push_data(8'hF8);
    push_data(8'h08);
    push_data(8'h03);
    push_data(8'h04);
    push_data(8'h80);
    push_data(8'h01);
    drain();

    for (int p = 0; p < 8; p++) begin
      reg_write(AddrWidth, row_widths[p][11:0]);
      src_pct = $urandom_range(0, 2) * 15;
      snk_pct = $urandom_range(0, 2) * 15;
      if (p == 3) begin
        src_pct = 0;
        hold_req = 1'b1;
      end
      push_random(PhaseItems);
      drain();
      if (p == 2) begin
        // Height at the current row closes the image until it is raised again.
        reg_write(AddrHeight, row_idx);
        push_data(8'h33);
        push_data(8'hCC);
        push_finish(8'h00);
        drain();
        reg_write(AddrHeight, 12'd4095);
      end
    end

    // Last image row with no idling: finish the image, then trailing bytes and a finish request.
    calm = 1'b1;
    reg_write(AddrWidth, 12'd5);
    reg_write(AddrHeight, row_idx + 12'd1);
    for (int k = 0; k < 22; k++) push_data(8'($urandom_range(0, 255)));
    push_finish(8'h00);
    drain();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d data bytes and %0d finish requests over %0d rows; %0d output bytes",
             n_data, n_finish, row_idx, n_checked);
    $display("checked, %0d of them row padding, with widths 0 to 4095 and heights 0 to 4095.",
             n_pad);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
